// ===== rtl/core/kmap_slot_allocator_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the kmap slot allocator
// Implication checks clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef KMAP_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define KMAP_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define KMAP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kmap assertion failed");

// next-cycle implication
`define KMAP_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kmap assertion failed");

`endif

// ===== rtl/core/kmap_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmap_pkg
// Shared constants, status codes, slot entry and sequencer state types.
// ----------------------------------------------------------------------------
package kmap_pkg;

   localparam int NUM_SLOTS  = 64;
   localparam int SLOT_W     = $clog2(NUM_SLOTS);
   localparam int FRAME_BITS = 20;
   localparam int COUNT_W    = 8;
   localparam int BUDGET_W   = $clog2(NUM_SLOTS + 1);
   localparam int STATUS_W   = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
   localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] COUNT_NEW  = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] COUNT_ZERO = '0;

   typedef enum logic [STATUS_W-1:0] {
      ST_DIRECT    = 3'd0,
      ST_HIT       = 3'd1,
      ST_NEW       = 3'd2,
      ST_NOFREE    = 3'd3,
      ST_UNMAPPED  = 3'd4,
      ST_NOTMAPPED = 3'd5,
      ST_FULL      = 3'd6
   } status_type;

   localparam logic KIND_MAP   = 1'b0;
   localparam logic KIND_UNMAP = 1'b1;

   // one RAM word per slot; a zero count means the slot is untagged
   typedef struct packed {
      logic [COUNT_W-1:0]    count;
      logic [FRAME_BITS-1:0] frame;
   } entry_type;

   typedef enum logic [9:0] {
      S_CLR       = 10'b00_0000_0001,
      S_IDLE      = 10'b00_0000_0010,
      S_LOOK      = 10'b00_0000_0100,
      S_LOOK_END  = 10'b00_0000_1000,
      S_DECIDE    = 10'b00_0001_0000,
      S_STEP      = 10'b00_0010_0000,
      S_FLUSH     = 10'b00_0100_0000,
      S_FLUSH_END = 10'b00_1000_0000,
      S_SRCH_RD   = 10'b01_0000_0000,
      S_SRCH_CHK  = 10'b10_0000_0000
   } state_type;

endpackage

// ===== rtl/core/kmap_slot_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmap_slot_allocator_top
// Persistent mapping-slot allocator: map/unmap page frames onto slots.
// ----------------------------------------------------------------------------
//  channel | ports                                   | transfer
//  --------+-----------------------------------------+---------------------------
//  request | start, busy, req_kind, req_page_frame   | start && !busy
//  result  | rsp_valid, rsp_status, rsp_slot         | rsp_valid, one cycle
//  csr     | csr_valid, csr_ready, csr_data          | csr_valid && csr_ready
//
// Direct frames answer in the cycle after the transfer. Anything else sweeps the
// slot RAM once for the lookup. A miss then probes the slots after the cursor
// one by one, and every wrap to slot zero adds a flush sweep of the whole RAM;
// all of these passes share the single RAM read port. After reset a clearing
// pass over every slot holds busy. Results cannot be stalled; busy stays high
// until the result is issued.
// ----------------------------------------------------------------------------
module kmap_slot_allocator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_kind,
   input  logic [kmap_pkg::FRAME_BITS-1:0] req_page_frame,
   output logic                            rsp_valid,
   output logic [kmap_pkg::STATUS_W-1:0]   rsp_status,
   output logic [kmap_pkg::SLOT_W-1:0]     rsp_slot,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kmap_pkg::FRAME_BITS-1:0] csr_data
);

   localparam logic [kmap_pkg::SLOT_W-1:0] LAST_SLOT =
      kmap_pkg::SLOT_W'(kmap_pkg::NUM_SLOTS - 1);
   localparam logic [kmap_pkg::BUDGET_W-1:0] FULL_BUDGET =
      kmap_pkg::BUDGET_W'(kmap_pkg::NUM_SLOTS);

   kmap_pkg::state_type                state_ff, state_in;
   logic [kmap_pkg::SLOT_W-1:0]        idx_ff, idx_in;
   logic                               dat_ok_ff, dat_ok_in;
   logic [kmap_pkg::SLOT_W-1:0]        dat_idx_ff, dat_idx_in;
   logic                               found_ff, found_in;
   logic [kmap_pkg::SLOT_W-1:0]        fslot_ff, fslot_in;
   logic [kmap_pkg::COUNT_W-1:0]       fcount_ff, fcount_in;
   logic                               kind_ff, kind_in;
   logic [kmap_pkg::FRAME_BITS-1:0]    frame_ff, frame_in;
   logic [kmap_pkg::SLOT_W-1:0]        cursor_ff, cursor_in;
   logic [kmap_pkg::BUDGET_W-1:0]      budget_ff, budget_in;
   logic [kmap_pkg::FRAME_BITS-1:0]    hms_ff, hms_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [kmap_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [kmap_pkg::SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;

   logic                               wr_en, rd_en;
   logic [kmap_pkg::SLOT_W-1:0]        wr_addr, rd_addr, c_next;
   kmap_pkg::entry_type                wr_data, rd_data;
   logic                               rsp_no_slot;

   kmap_ram #(
      .WIDTH ($bits(kmap_pkg::entry_type)),
      .DEPTH (kmap_pkg::NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy       = (state_ff != kmap_pkg::S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign c_next     = (cursor_ff == LAST_SLOT) ? '0 : cursor_ff + 1'b1;

   // answers that carry no slot
   assign rsp_no_slot = (rsp_status_ff == kmap_pkg::ST_DIRECT) ||
                        (rsp_status_ff == kmap_pkg::ST_NOFREE) ||
                        (rsp_status_ff == kmap_pkg::ST_NOTMAPPED);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      dat_ok_in     = 1'b0;
      dat_idx_in    = dat_idx_ff;
      found_in      = found_ff;
      fslot_in      = fslot_ff;
      fcount_in     = fcount_ff;
      kind_in       = kind_ff;
      frame_in      = frame_ff;
      cursor_in     = cursor_ff;
      budget_in     = budget_ff;
      hms_in        = (csr_valid && csr_ready) ? csr_data : hms_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      wr_en         = 1'b0;
      wr_addr       = dat_idx_ff;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;

      // lookup: keep the lowest tagged slot holding the frame
      if ((state_ff == kmap_pkg::S_LOOK || state_ff == kmap_pkg::S_LOOK_END) && dat_ok_ff &&
          !found_ff && rd_data.count != kmap_pkg::COUNT_ZERO && rd_data.frame == frame_ff) begin
         found_in  = 1'b1;
         fslot_in  = dat_idx_ff;
         fcount_in = rd_data.count;
      end

      // flush: slots with a single reference are freed
      if ((state_ff == kmap_pkg::S_FLUSH || state_ff == kmap_pkg::S_FLUSH_END) && dat_ok_ff &&
          rd_data.count == kmap_pkg::COUNT_ONE) begin
         wr_en         = 1'b1;
         wr_addr       = dat_idx_ff;
         wr_data.count = kmap_pkg::COUNT_ZERO;
         wr_data.frame = rd_data.frame;
      end

      case (state_ff)
         kmap_pkg::S_CLR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = '0;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == LAST_SLOT) begin
               state_in = kmap_pkg::S_IDLE;
            end
         end
         kmap_pkg::S_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               frame_in = req_page_frame;
               if (req_kind == kmap_pkg::KIND_MAP && req_page_frame < hms_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = kmap_pkg::ST_DIRECT;
                  rsp_slot_in   = '0;
               end else begin
                  idx_in   = '0;
                  found_in = 1'b0;
                  state_in = kmap_pkg::S_LOOK;
               end
            end
         end
         kmap_pkg::S_LOOK, kmap_pkg::S_FLUSH: begin
            rd_en      = 1'b1;
            rd_addr    = idx_ff;
            dat_ok_in  = 1'b1;
            dat_idx_in = idx_ff;
            idx_in     = idx_ff + 1'b1;
            if (idx_ff == LAST_SLOT) begin
               state_in = (state_ff == kmap_pkg::S_LOOK) ? kmap_pkg::S_LOOK_END
                                                         : kmap_pkg::S_FLUSH_END;
            end
         end
         kmap_pkg::S_LOOK_END: begin
            state_in = kmap_pkg::S_DECIDE;
         end
         kmap_pkg::S_FLUSH_END: begin
            state_in = kmap_pkg::S_SRCH_RD;
         end
         kmap_pkg::S_DECIDE: begin
            state_in     = kmap_pkg::S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_slot_in  = '0;
            wr_addr      = fslot_ff;
            wr_data.frame = frame_ff;
            if (kind_ff == kmap_pkg::KIND_UNMAP) begin
               if (found_ff && fcount_ff > kmap_pkg::COUNT_ONE) begin
                  wr_en         = 1'b1;
                  wr_data.count = fcount_ff - 1'b1;
                  rsp_status_in = kmap_pkg::ST_UNMAPPED;
                  rsp_slot_in   = fslot_ff;
               end else begin
                  rsp_status_in = kmap_pkg::ST_NOTMAPPED;
               end
            end else if (found_ff) begin
               rsp_slot_in = fslot_ff;
               if (fcount_ff == kmap_pkg::COUNT_MAX) begin
                  rsp_status_in = kmap_pkg::ST_FULL;
               end else begin
                  wr_en         = 1'b1;
                  wr_data.count = fcount_ff + 1'b1;
                  rsp_status_in = kmap_pkg::ST_HIT;
               end
            end else begin
               // miss: start the cursor search
               rsp_valid_in = 1'b0;
               budget_in    = FULL_BUDGET;
               state_in     = kmap_pkg::S_STEP;
            end
         end
         kmap_pkg::S_STEP: begin
            cursor_in = c_next;
            if (c_next == '0) begin
               budget_in = FULL_BUDGET;
               idx_in    = '0;
               state_in  = kmap_pkg::S_FLUSH;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = c_next;
               state_in = kmap_pkg::S_SRCH_CHK;
            end
         end
         kmap_pkg::S_SRCH_RD: begin
            rd_en    = 1'b1;
            rd_addr  = cursor_ff;
            state_in = kmap_pkg::S_SRCH_CHK;
         end
         kmap_pkg::S_SRCH_CHK: begin
            if (rd_data.count == kmap_pkg::COUNT_ZERO) begin
               wr_en         = 1'b1;
               wr_addr       = cursor_ff;
               wr_data.count = kmap_pkg::COUNT_NEW;
               wr_data.frame = frame_ff;
               rsp_valid_in  = 1'b1;
               rsp_status_in = kmap_pkg::ST_NEW;
               rsp_slot_in   = cursor_ff;
               state_in      = kmap_pkg::S_IDLE;
            end else if (budget_ff == kmap_pkg::BUDGET_W'(1)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = kmap_pkg::ST_NOFREE;
               rsp_slot_in   = '0;
               state_in      = kmap_pkg::S_IDLE;
            end else begin
               budget_in = budget_ff - 1'b1;
               state_in  = kmap_pkg::S_STEP;
            end
         end
         default: begin
            state_in = kmap_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kmap_pkg::S_CLR;
         idx_ff       <= '0;
         dat_ok_ff    <= 1'b0;
         cursor_ff    <= LAST_SLOT;
         hms_ff       <= kmap_pkg::FRAME_BITS'(229376);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         dat_ok_ff    <= dat_ok_in;
         cursor_ff    <= cursor_in;
         hms_ff       <= hms_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dat_idx_ff    <= dat_idx_in;
      found_ff      <= found_in;
      fslot_ff      <= fslot_in;
      fcount_ff     <= fcount_in;
      kind_ff       <= kind_in;
      frame_ff      <= frame_in;
      budget_ff     <= budget_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

`include "kmap_slot_allocator_top_assert.svh"

   // an accepted request either answers at once or keeps the block busy
   `KMAP_ASSERT_NXT(a_accept_progress, start && !busy, busy || rsp_valid)
   // answers without a slot carry slot zero
   `KMAP_ASSERT_IMP(a_slot_zero, rsp_valid && rsp_no_slot, rsp_slot == '0)
   // the sweeps never read and write the same slot in one cycle
   `KMAP_ASSERT_IMP(a_no_rw_clash, wr_en && rd_en, wr_addr != rd_addr)

endmodule

// ===== rtl/core/kmap_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmap_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kmap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator testbench
// Drives map/unmap requests and highmem boundary writes into the slot
// allocator, predicts every answer with a behavioural slot table and checks
// status and slot of each result in order.
// ----------------------------------------------------------------------------

import kmap_pkg::*;

// behavioural slot table and queue of predicted answers
class slot_table_sb;
   logic [FRAME_BITS-1:0] highmem;
   logic [COUNT_W-1:0]    counts[NUM_SLOTS];
   logic [FRAME_BITS-1:0] frames[NUM_SLOTS];
   bit                    in_use[NUM_SLOTS];
   int                    cur;
   status_type            want_status[$];
   logic [SLOT_W-1:0]     want_slot[$];
   int                    errors;
   int                    mismatches;

   function new();
      highmem = FRAME_BITS'(229376);
      for (int i = 0; i < NUM_SLOTS; i++) begin
         counts[i] = '0;
         frames[i] = '0;
         in_use[i] = 0;
      end
      cur = NUM_SLOTS - 1;
      errors = 0;
      mismatches = 0;
   endfunction

   function int find_frame(logic [FRAME_BITS-1:0] f);
      for (int i = 0; i < NUM_SLOTS; i++)
         if (in_use[i] && frames[i] == f) return i;
      return -1;
   endfunction

   // round-robin search with a flush of single-reference slots at each wrap
   function int claim(logic [FRAME_BITS-1:0] f);
      int budget;
      budget = NUM_SLOTS;
      forever begin
         cur = (cur + 1) % NUM_SLOTS;
         if (cur == 0) begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (counts[i] == COUNT_ONE) begin
                  counts[i] = '0;
                  in_use[i] = 0;
               end
            budget = NUM_SLOTS;
         end
         if (counts[cur] == COUNT_ZERO) break;
         budget--;
         if (budget == 0) return -1;
      end
      frames[cur] = f;
      in_use[cur] = 1;
      counts[cur] = COUNT_NEW;
      return cur;
   endfunction

   // note one accepted request
   function void note_request(logic kind, logic [FRAME_BITS-1:0] f);
      status_type st;
      int s;
      int slot_used;
      slot_used = 0;
      if (kind == KIND_MAP) begin
         if (f < highmem) st = ST_DIRECT;
         else begin
            s = find_frame(f);
            if (s >= 0) begin
               slot_used = s;
               if (counts[s] == COUNT_MAX) st = ST_FULL;
               else begin
                  counts[s]++;
                  st = ST_HIT;
               end
            end else begin
               s = claim(f);
               if (s >= 0) begin
                  slot_used = s;
                  st = ST_NEW;
               end else st = ST_NOFREE;
            end
         end
      end else begin
         s = find_frame(f);
         if (s >= 0 && counts[s] > COUNT_ONE) begin
            counts[s]--;
            slot_used = s;
            st = ST_UNMAPPED;
         end else st = ST_NOTMAPPED;
      end
      want_status.push_back(st);
      want_slot.push_back(SLOT_W'(slot_used));
   endfunction

   // compare one result with the oldest prediction
   function void check_answer(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] sl);
      status_type es;
      logic [SLOT_W-1:0] esl;
      if (want_status.size() == 0) begin
         errors++;
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: status %0d slot %0d", st, sl);
         return;
      end
      es = want_status.pop_front();
      esl = want_slot.pop_front();
      if (st !== es || sl !== esl) begin
         errors++;
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                     es, esl, st, sl);
      end
   endfunction
endclass

module testbench;
   localparam int WATCHDOG_LIMIT = 40000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_kind = KIND_MAP;
   logic [FRAME_BITS-1:0] req_page_frame = '0;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_W-1:0]     rsp_slot;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [FRAME_BITS-1:0] csr_data = '0;

   slot_table_sb table_sb = new();
   int idle_cycles = 0;

   kmap_slot_allocator_top u_dut (.*);

   always #5 clock = ~clock;

   // result monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) table_sb.check_answer(rsp_status, rsp_slot);
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // one request transfer, with a random gap in front; start stays high after
   // the transfer until the next request, a gap or drain() takes it down
   task automatic send_request(logic kind, logic [FRAME_BITS-1:0] f, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_page_frame <= f;
      do @(posedge clock); while (busy);
      table_sb.note_request(kind, f);
   endtask

   // wait for all answers, then let any late work settle
   task automatic drain();
      start <= 1'b0;
      while (table_sb.want_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_highmem(logic [FRAME_BITS-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      table_sb.highmem = v;
      csr_valid <= 1'b0;
   endtask

   // random frame from a small pool above the boundary, so hits and unmaps occur
   function automatic logic [FRAME_BITS-1:0] pool_frame(logic [FRAME_BITS-1:0] base, int n);
      return base + FRAME_BITS'($urandom_range(0, n - 1));
   endfunction

   initial begin
      logic [FRAME_BITS-1:0] base;
      logic [FRAME_BITS-1:0] f;
      int pool;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: direct, new, hit, unmap, not mapped, extremes
      send_request(KIND_MAP, '0);
      send_request(KIND_MAP, FRAME_BITS'(229375));
      send_request(KIND_MAP, FRAME_BITS'(229376));
      send_request(KIND_MAP, FRAME_BITS'(229376));
      send_request(KIND_UNMAP, FRAME_BITS'(229376));
      send_request(KIND_UNMAP, FRAME_BITS'(229376));
      send_request(KIND_UNMAP, FRAME_BITS'(229376));
      send_request(KIND_UNMAP, '0);
      send_request(KIND_MAP, '1);
      send_request(KIND_UNMAP, '1);
      write_highmem('0);
      send_request(KIND_MAP, '0);
      send_request(KIND_UNMAP, '0);
      // count saturation on one frame, back to back
      repeat (256) send_request(KIND_MAP, FRAME_BITS'(5), 1);
      repeat (3) send_request(KIND_UNMAP, FRAME_BITS'(5));
      write_highmem('1);
      send_request(KIND_MAP, FRAME_BITS'(5));
      send_request(KIND_MAP, '1);
      send_request(KIND_UNMAP, '1);
      // exhaust the slots with held references
      write_highmem(FRAME_BITS'(16));
      for (int i = 0; i < 70; i++) send_request(KIND_MAP, FRAME_BITS'(1000 + i), 1);
      for (int i = 0; i < 70; i++) send_request(KIND_UNMAP, FRAME_BITS'(1000 + i), 1);
      for (int i = 0; i < 20; i++) send_request(KIND_MAP, FRAME_BITS'(5000 + i));

      // random phases under several boundaries
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_highmem(FRAME_BITS'(229376));
            1: write_highmem(FRAME_BITS'($urandom));
            2: write_highmem('0);
            default: write_highmem(FRAME_BITS'($urandom));
         endcase
         base = table_sb.highmem > FRAME_BITS'(1048575 - 200) ? FRAME_BITS'(1048575 - 200)
                                                              : table_sb.highmem;
         pool = (ph % 2 == 0) ? 40 : 90;
         for (int i = 0; i < 200; i++) begin
            case ($urandom_range(0, 9))
               0: f = FRAME_BITS'($urandom);
               1: f = base - FRAME_BITS'($urandom_range(0, 3));
               default: f = pool_frame(base, pool);
            endcase
            send_request(($urandom_range(0, 9) < 4) ? KIND_UNMAP : KIND_MAP, f,
                         ($urandom_range(0, 3) == 0));
         end
      end

      drain();
      repeat (200) @(posedge clock);
      if (table_sb.errors == 0 && table_sb.want_status.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
